// ===== rtl/dpg_pkg.sv =====
// ----------------------------------------------------------------------------
// dpg_pkg - distance pan gain shared definitions
// Field widths, register indexes and the divider side-band record.
// ----------------------------------------------------------------------------
`default_nettype none

package dpg_pkg;

   localparam int DIST_W     = 16;
   localparam int BEARING_W  = 9;
   localparam int FLOOR_W    = 13;
   localparam int MAG_W      = 9;
   localparam int ANGLE_W    = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // divider operands: numerator multiplier and denominator
   localparam int NUM_W = 16;
   localparam int DEN_W = 18;
   localparam int REM_W = DEN_W + 1;

   localparam int FB_FULL   = 360;
   localparam int ANG_FOLD  = 180;
   localparam int ANG_SPLIT = 91;
   localparam int PAN_SPAN  = 90;

   localparam logic [CSR_IDX_W-1:0] REG_NEAR       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MID        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAR        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_SLOPE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRONT_BACK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SIDE_FLOOR = 3'd6;

   localparam logic [DIST_W-1:0]  NEAR_RESET  = 16'd500;
   localparam logic [DIST_W-1:0]  MID_RESET   = 16'd1000;
   localparam logic [DIST_W-1:0]  FAR_RESET   = 16'd3000;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 13'd410;

   typedef struct packed {
      logic               positional;
      logic               ov_zero;
      logic               ov_one;
      logic               to_right;
      logic [MAG_W-1:0]   mag;
      logic [ANGLE_W-1:0] angle;
   } dpg_meta_type;

endpackage

`default_nettype wire

// ===== rtl/dpg_req_if.sv =====
// ----------------------------------------------------------------------------
// dpg_req_if - voice request channel
// One beat carries a voice's positional flag, distance and bearing.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpg_req_if import dpg_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        positional;
   logic [DIST_W-1:0]           distance;
   logic signed [BEARING_W-1:0] bearing;

   modport source (output valid, output positional, output distance, output bearing,
                   input ready);
   modport sink   (input valid, input positional, input distance, input bearing,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/dpg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dpg_rsp_if - gain result channel
// One beat carries the right and left channel gains.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpg_rsp_if #(parameter int GAIN_W = 13);
   logic              valid;
   logic              ready;
   logic [GAIN_W-1:0] right_gain;
   logic [GAIN_W-1:0] left_gain;

   modport source (output valid, output right_gain, output left_gain, input ready);
   modport sink   (input valid, input right_gain, input left_gain, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpg_csr_if.sv =====
// ----------------------------------------------------------------------------
// dpg_csr_if - register write channel
// One beat writes data to the register selected by index.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpg_csr_if import dpg_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dpg_div.sv =====
// ----------------------------------------------------------------------------
// dpg_div - pipelined restoring divider
// Computes num * 2^(QUOT_W-1) / den, one quotient bit per stage, num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module dpg_div import dpg_pkg::*; #(
   parameter int QUOT_W = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  dpg_meta_type      in_meta,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [QUOT_W-1:0] out_quot,
   output dpg_meta_type      out_meta
);

   localparam int N = QUOT_W;

   logic [N-1:0]      vld_ff;
   logic [N:0]        rdy;
   logic [DEN_W-1:0]  rem_ff  [N];
   logic [DEN_W-1:0]  den_ff  [N];
   logic [QUOT_W-1:0] quot_ff [N];
   dpg_meta_type      meta_ff [N];

   logic [DEN_W-1:0]  rem_in  [N];
   logic [DEN_W-1:0]  den_in  [N];
   logic [QUOT_W-1:0] quot_in [N];
   dpg_meta_type      meta_in [N];
   logic [N-1:0]      vld_in;
   logic [REM_W-1:0]  trial   [N];
   logic [N-1:0]      take;

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            trial[k]   = REM_W'(in_num);
            den_in[k]  = in_den;
            quot_in[k] = '0;
            meta_in[k] = in_meta;
            vld_in[k]  = in_valid;
         end else begin
            trial[k]   = {rem_ff[k-1], 1'b0};
            den_in[k]  = den_ff[k-1];
            quot_in[k] = quot_ff[k-1];
            meta_in[k] = meta_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         take[k] = trial[k] >= REM_W'(den_in[k]);
         if (take[k]) begin
            rem_in[k] = DEN_W'(trial[k] - REM_W'(den_in[k]));
         end else begin
            rem_in[k] = DEN_W'(trial[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (rdy[k]) begin
            rem_ff[k]  <= rem_in[k];
            den_ff[k]  <= den_in[k];
            quot_ff[k] <= {quot_in[k][QUOT_W-2:0], take[k]};
            meta_ff[k] <= meta_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_quot  = quot_ff[N-1];
   assign out_meta  = meta_ff[N-1];

endmodule

`default_nettype wire

// ===== rtl/distance_pan_gain_unit.sv =====
// ----------------------------------------------------------------------------
// distance_pan_gain_unit - per-voice distance rolloff and stereo pan gains
// Voice beats arrive on req_bus (positional, distance, bearing); gain beats
// leave on rsp_bus (right_gain, left_gain, GAIN_FRAC_BITS fraction bits).
// Registers are written through csr_bus, index as listed in dpg_pkg; the
// port is always ready and writes are expected only while the block is idle.
// From accept to rsp valid a beat passes two setup stages, one divider stage
// per quotient bit, then six stages for the front/back and pan scaling.
// One beat is accepted per cycle while rsp_bus does not stall the pipe;
// the depth is set by the bit-per-stage rolloff divider.
// Every stage holds its own valid bit, so a stalled rsp_bus only fills the
// pipe from the far end: empty stages keep taking beats until the pipe is
// full, and nothing is dropped or repeated.
// A synchronous reset empties the pipeline and restores the register
// defaults (near 500, mid 1000, far 3000, side floor 410, modes off).
// ----------------------------------------------------------------------------
`default_nettype none

module distance_pan_gain_unit import dpg_pkg::*; #(
   parameter int GAIN_FRAC_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   dpg_req_if.sink   req_bus,
   dpg_rsp_if.source rsp_bus,
   dpg_csr_if.sink   csr_bus
);

   localparam int GW     = GAIN_FRAC_BITS;
   localparam int QUOT_W = GW + 1;
   localparam int PFB_W  = GW + 10;
   localparam int SH1    = GW + 10;
   localparam int RC_W   = GW + 2;
   localparam int M1_W   = PFB_W + RC_W;
   localparam int FAC_W  = GW + 7;
   localparam int P2_W   = QUOT_W + FAC_W;
   localparam int Y_W    = GW + 8;
   localparam int SH2    = GW + 8;
   localparam int M2_W   = Y_W + RC_W;
   localparam int FLW    = (QUOT_W > FLOOR_W) ? QUOT_W : FLOOR_W;
   localparam int R360   = (2 ** SH1) / FB_FULL;
   localparam int R90    = (2 ** SH2) / PAN_SPAN;

   localparam logic [QUOT_W-1:0] ONE_C      = {1'b1, {GW{1'b0}}};
   localparam logic [RC_W-1:0]   R360_C     = RC_W'(R360);
   localparam logic [RC_W-1:0]   R90_C      = RC_W'(R90);
   localparam logic [FAC_W-1:0]  FULL_SCALE = FAC_W'(PAN_SPAN * (2 ** GW));

   // configuration registers
   logic [DIST_W-1:0]  near_ff, mid_ff, far_ff;
   logic               two_slope_ff, pan_ff, front_back_ff;
   logic [FLOOR_W-1:0] floor_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff       <= NEAR_RESET;
         mid_ff        <= MID_RESET;
         far_ff        <= FAR_RESET;
         two_slope_ff  <= 1'b0;
         pan_ff        <= 1'b0;
         front_back_ff <= 1'b0;
         floor_ff      <= FLOOR_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_NEAR:       near_ff       <= csr_bus.data;
            REG_MID:        mid_ff        <= csr_bus.data;
            REG_FAR:        far_ff        <= csr_bus.data;
            REG_TWO_SLOPE:  two_slope_ff  <= csr_bus.data[0];
            REG_PAN:        pan_ff        <= csr_bus.data[0];
            REG_FRONT_BACK: front_back_ff <= csr_bus.data[0];
            REG_SIDE_FLOOR: floor_ff      <= csr_bus.data[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1: input register
   logic                        s1_vld_ff, s1_rdy;
   logic                        s1_pos_ff;
   logic [DIST_W-1:0]           s1_dist_ff;
   logic signed [BEARING_W-1:0] s1_bear_ff;

   // stage 2: divider operands
   logic               s2_vld_ff, s2_rdy;
   logic [NUM_W-1:0]   s2_num_ff, s2_num_in;
   logic [DEN_W-1:0]   s2_den_ff, s2_den_in;
   dpg_meta_type       s2_meta_ff, s2_meta_in;

   logic               div_in_ready, div_out_valid, div_out_ready;
   logic [QUOT_W-1:0]  div_quot;
   dpg_meta_type       div_meta;

   assign s2_rdy      = !s2_vld_ff || div_in_ready;
   assign s1_rdy      = !s1_vld_ff || s2_rdy;
   assign req_bus.ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= req_bus.valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_pos_ff  <= req_bus.positional;
         s1_dist_ff <= req_bus.distance;
         s1_bear_ff <= req_bus.bearing;
      end
      if (s2_rdy) begin
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_meta_ff <= s2_meta_in;
      end
   end

   // rolloff segment selection and bearing fold
   logic                above_far, below_near, first_seg, span_pos;
   logic [DIST_W:0]     d_off;
   logic signed [DIST_W:0] span;
   logic [DIST_W-1:0]   r2, d2;
   logic [MAG_W-1:0]    mag;

   always_comb begin
      above_far  = s1_dist_ff > far_ff;
      below_near = s1_dist_ff < near_ff;
      d_off      = {1'b0, s1_dist_ff} - {1'b0, near_ff};
      span       = $signed({1'b0, mid_ff}) - $signed({1'b0, near_ff});
      first_seg  = !two_slope_ff || ($signed(d_off) < span);
      span_pos   = !span[DIST_W] && (span != '0);
      r2         = far_ff - mid_ff;
      d2         = s1_dist_ff - mid_ff;
      mag        = s1_bear_ff[BEARING_W-1] ? (~s1_bear_ff + 1'b1) : s1_bear_ff;

      s2_meta_in.positional = s1_pos_ff;
      s2_meta_in.to_right   = !s1_bear_ff[BEARING_W-1];
      s2_meta_in.mag        = mag;
      if (mag >= MAG_W'(ANG_SPLIT)) begin
         if (mag >= MAG_W'(ANG_FOLD)) begin
            s2_meta_in.angle = '0;
         end else begin
            s2_meta_in.angle = ANGLE_W'(MAG_W'(ANG_FOLD) - mag);
         end
      end else begin
         s2_meta_in.angle = ANGLE_W'(mag);
      end

      s2_meta_in.ov_zero = 1'b0;
      s2_meta_in.ov_one  = 1'b0;
      s2_num_in          = '0;
      s2_den_in          = '0;
      if (above_far) begin
         s2_meta_in.ov_zero = 1'b1;
      end else if (below_near) begin
         s2_meta_in.ov_one = 1'b1;
      end else if (first_seg) begin
         s2_meta_in.ov_zero = !span_pos;
         s2_num_in = span[NUM_W-1:0];
         s2_den_in = DEN_W'(span[NUM_W-1:0]) + DEN_W'(d_off[DIST_W-1:0]);
      end else begin
         s2_meta_in.ov_zero = (r2 == '0);
         s2_num_in = far_ff - s1_dist_ff;
         s2_den_in = {({1'b0, r2} + {1'b0, d2}), 1'b0};
      end
   end

   dpg_div #(.QUOT_W(QUOT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_meta   (s2_meta_ff),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_quot  (div_quot),
      .out_meta  (div_meta)
   );

   // post-divider stages p1..p6
   logic [5:0] p_vld_ff;
   logic [6:0] p_rdy;

   always_comb begin
      p_rdy[6] = rsp_bus.ready;
      for (int k = 5; k >= 0; k--) begin
         p_rdy[k] = !p_vld_ff[k] || p_rdy[k+1];
      end
   end

   assign div_out_ready = p_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= '0;
      end else begin
         if (p_rdy[0]) begin
            p_vld_ff[0] <= div_out_valid;
         end
         for (int k = 1; k < 6; k++) begin
            if (p_rdy[k]) begin
               p_vld_ff[k] <= p_vld_ff[k-1];
            end
         end
      end
   end

   logic [4:0]        pos_ff, right_side_ff;
   logic [QUOT_W-1:0] g_ff [5];
   logic [QUOT_W-1:0] n_ff [3:5];

   logic [PFB_W-1:0]  p1_prodfb_ff, p2_prodfb_ff;
   logic [FAC_W-1:0]  p1_fac_ff, p2_fac_ff, p3_fac_ff;
   logic [QUOT_W-1:0] p2_est1_ff;
   logic [P2_W-1:0]   p4_prod2_ff;
   logic [Y_W-1:0]    p5_y_ff;
   logic [QUOT_W-1:0] p5_est2_ff;
   logic [QUOT_W-1:0] right_ff, left_ff;

   logic [QUOT_W-1:0] g_sel, fl_sat, other;
   logic [MAG_W-1:0]  fb_factor;
   logic [FLW-1:0]    fl_ext;
   logic [GW+7:0]     floor_prod;
   logic [M1_W-1:0]   m1;
   logic [PFB_W-1:0]  rem1;
   logic [Y_W-1:0]    y;
   logic [M2_W-1:0]   m2;
   logic [Y_W-1:0]    rem2;

   always_comb begin
      if (div_meta.ov_zero) begin
         g_sel = '0;
      end else if (div_meta.ov_one) begin
         g_sel = ONE_C;
      end else begin
         g_sel = div_quot;
      end
      if (pan_ff && front_back_ff) begin
         fb_factor = MAG_W'(FB_FULL) - div_meta.mag;
      end else begin
         fb_factor = MAG_W'(FB_FULL);
      end
      fl_ext = FLW'(floor_ff);
      fl_sat = (fl_ext > FLW'(ONE_C)) ? ONE_C : QUOT_W'(fl_ext);
      floor_prod = (GW + 8)'(ONE_C - fl_sat) * (GW + 8)'(div_meta.angle);

      m1   = M1_W'(p1_prodfb_ff) * M1_W'(R360_C);
      rem1 = p2_prodfb_ff - PFB_W'(p2_est1_ff) * PFB_W'(FB_FULL);

      y    = p4_prod2_ff[GW +: Y_W];
      m2   = M2_W'(y) * M2_W'(R90_C);
      rem2 = p5_y_ff - Y_W'(p5_est2_ff) * Y_W'(PAN_SPAN);
      other = p5_est2_ff + QUOT_W'(rem2 >= Y_W'(PAN_SPAN));
   end

   always_ff @(posedge clock) begin
      if (p_rdy[0]) begin
         pos_ff[0]        <= div_meta.positional;
         right_side_ff[0] <= div_meta.to_right;
         g_ff[0]          <= g_sel;
         p1_prodfb_ff     <= PFB_W'(g_sel) * PFB_W'(fb_factor);
         p1_fac_ff        <= FULL_SCALE - FAC_W'(floor_prod);
      end
      if (p_rdy[1]) begin
         pos_ff[1]        <= pos_ff[0];
         right_side_ff[1] <= right_side_ff[0];
         g_ff[1]          <= g_ff[0];
         p2_prodfb_ff     <= p1_prodfb_ff;
         p2_est1_ff       <= m1[SH1 +: QUOT_W];
         p2_fac_ff        <= p1_fac_ff;
      end
      if (p_rdy[2]) begin
         pos_ff[2]        <= pos_ff[1];
         right_side_ff[2] <= right_side_ff[1];
         g_ff[2]          <= g_ff[1];
         n_ff[3]          <= p2_est1_ff + QUOT_W'(rem1 >= PFB_W'(FB_FULL));
         p3_fac_ff        <= p2_fac_ff;
      end
      if (p_rdy[3]) begin
         pos_ff[3]        <= pos_ff[2];
         right_side_ff[3] <= right_side_ff[2];
         g_ff[3]          <= g_ff[2];
         n_ff[4]          <= n_ff[3];
         p4_prod2_ff      <= P2_W'(n_ff[3]) * P2_W'(p3_fac_ff);
      end
      if (p_rdy[4]) begin
         pos_ff[4]        <= pos_ff[3];
         right_side_ff[4] <= right_side_ff[3];
         g_ff[4]          <= g_ff[3];
         n_ff[5]          <= n_ff[4];
         p5_y_ff          <= y;
         p5_est2_ff       <= m2[SH2 +: QUOT_W];
      end
      if (p_rdy[5]) begin
         if (!pos_ff[4]) begin
            right_ff <= ONE_C;
            left_ff  <= ONE_C;
         end else if (!pan_ff) begin
            right_ff <= g_ff[4];
            left_ff  <= g_ff[4];
         end else if (right_side_ff[4]) begin
            right_ff <= other;
            left_ff  <= n_ff[5];
         end else begin
            right_ff <= n_ff[5];
            left_ff  <= other;
         end
      end
   end

   assign rsp_bus.valid      = p_vld_ff[5];
   assign rsp_bus.right_gain = right_ff;
   assign rsp_bus.left_gain  = left_ff;

endmodule

`default_nettype wire
